@@ rtl/pec_pkg.sv @@
// ----------------------------------------------------------------------------
// pec_pkg: shared types and constants of the path edge crossing checker
// Holds the configuration register map and the near-endpoint limits.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int NUM_EDGE_REGS = 8;
  localparam int EDGE_SEL_W = 3;

  typedef enum logic [EDGE_SEL_W-1:0] {
    CFG_EDGE_A_SX = 3'd0,
    CFG_EDGE_A_SY = 3'd1,
    CFG_EDGE_A_EX = 3'd2,
    CFG_EDGE_A_EY = 3'd3,
    CFG_EDGE_B_SX = 3'd4,
    CFG_EDGE_B_SY = 3'd5,
    CFG_EDGE_B_EX = 3'd6,
    CFG_EDGE_B_EY = 3'd7
  } cfg_idx_t;

  // Endpoints closer than 0.01 m (squared distance below 105 LSB^2) only touch.
  localparam int NEAR_SPAN = 10;
  localparam int NEAR_MAG_W = 4;
  localparam int NEAR_SUM_W = 9;
  localparam logic [NEAR_SUM_W-1:0] NEAR_LIMIT = 9'd105;

endpackage

@@ rtl/pec_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pec_cfg_regs: forbidden edge endpoint registers
// Eight signed coordinates written through the configuration channel.
// ----------------------------------------------------------------------------
module pec_cfg_regs #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [pec_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  output logic signed [COORD_BITS-1:0]         edge_coord [pec_pkg::NUM_EDGE_REGS]
);

  logic signed [COORD_BITS-1:0] edge_r [pec_pkg::NUM_EDGE_REGS];
  logic                         in_map;
  pec_pkg::cfg_idx_t            sel;

  assign in_map = (cfg_index[pec_pkg::CFG_INDEX_W-1:pec_pkg::EDGE_SEL_W] == '0);
  assign sel    = pec_pkg::cfg_idx_t'(cfg_index[pec_pkg::EDGE_SEL_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pec_pkg::NUM_EDGE_REGS; i++) begin
        edge_r[i] <= '0;
      end
    end else if (cfg_valid && in_map) begin
      edge_r[sel] <= $signed(cfg_data);
    end
  end

  assign edge_coord = edge_r;

endmodule

@@ rtl/pec_edge_test.sv @@
// ----------------------------------------------------------------------------
// pec_edge_test: segment against one forbidden edge
// Registers the eight orientation products and the near-endpoint flag, then
// compares the products to decide a strict crossing.
// ----------------------------------------------------------------------------
module pec_edge_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [COORD_BITS-1:0]  x1,
  input  logic signed [COORD_BITS-1:0]  y1,
  input  logic signed [COORD_BITS-1:0]  x2,
  input  logic signed [COORD_BITS-1:0]  y2,
  input  logic signed [COORD_BITS-1:0]  x3,
  input  logic signed [COORD_BITS-1:0]  y3,
  input  logic signed [COORD_BITS-1:0]  x4,
  input  logic signed [COORD_BITS-1:0]  y4,
  output logic                          hit
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam logic signed [DW-1:0] SPAN_HI = DW'(pec_pkg::NEAR_SPAN);
  localparam logic signed [DW-1:0] SPAN_LO = -DW'(pec_pkg::NEAR_SPAN);

  function automatic logic near_pt(input logic signed [DW-1:0] dx,
                                   input logic signed [DW-1:0] dy);
    logic                                  close;
    logic signed [DW-1:0]                  ax;
    logic signed [DW-1:0]                  ay;
    logic [pec_pkg::NEAR_MAG_W-1:0]        mx;
    logic [pec_pkg::NEAR_MAG_W-1:0]        my;
    logic [pec_pkg::NEAR_SUM_W-1:0]        sum;
    close = (dx >= SPAN_LO) && (dx <= SPAN_HI) && (dy >= SPAN_LO) && (dy <= SPAN_HI);
    ax    = dx[DW-1] ? -dx : dx;
    ay    = dy[DW-1] ? -dy : dy;
    mx    = ax[pec_pkg::NEAR_MAG_W-1:0];
    my    = ay[pec_pkg::NEAR_MAG_W-1:0];
    sum   = pec_pkg::NEAR_SUM_W'(mx * mx) + pec_pkg::NEAR_SUM_W'(my * my);
    return close && (sum < pec_pkg::NEAR_LIMIT);
  endfunction

  logic signed [DW-1:0] dx31, dy31, dx41, dy41, dx32, dy32, dx42, dy42, dx21, dy21;
  logic signed [PW-1:0] l1_r, r1_r, l2_r, r2_r, l3_r, r3_r, l4_r, r4_r;
  logic                 near_r;
  logic                 c1, c2, c3, c4;

  assign dx31 = DW'(x3) - DW'(x1);
  assign dy31 = DW'(y3) - DW'(y1);
  assign dx41 = DW'(x4) - DW'(x1);
  assign dy41 = DW'(y4) - DW'(y1);
  assign dx32 = DW'(x3) - DW'(x2);
  assign dy32 = DW'(y3) - DW'(y2);
  assign dx42 = DW'(x4) - DW'(x2);
  assign dy42 = DW'(y4) - DW'(y2);
  assign dx21 = DW'(x2) - DW'(x1);
  assign dy21 = DW'(y2) - DW'(y1);

  always_ff @(posedge clk) begin
    if (load) begin
      l1_r   <= dy41 * dx31;
      r1_r   <= dy31 * dx41;
      l2_r   <= dy42 * dx32;
      r2_r   <= dy32 * dx42;
      l3_r   <= dy31 * dx21;
      r3_r   <= dy21 * dx31;
      l4_r   <= dy41 * dx21;
      r4_r   <= dy21 * dx41;
      near_r <= near_pt(dx31, dy31) || near_pt(dx41, dy41) ||
                near_pt(dx32, dy32) || near_pt(dx42, dy42);
    end
  end

  assign c1  = l1_r > r1_r;
  assign c2  = l2_r > r2_r;
  assign c3  = l3_r > r3_r;
  assign c4  = l4_r > r4_r;
  assign hit = (c1 != c2) && (c3 != c4) && !near_r;

endmodule

@@ rtl/path_edge_crossing_checker.sv @@
// ----------------------------------------------------------------------------
// path_edge_crossing_checker: trajectory segment versus two forbidden edges
// Throughput: one point per cycle unless out_tready holds the pipeline back;
// the orientation products are registered between the input stage and the
// output stage.
// Reset clears the previous point, the sticky flag and the edge registers.
// ----------------------------------------------------------------------------
module path_edge_crossing_checker #(
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // first_point
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // segment_crosses, any_crossing
  output logic [7:0]                             out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pec_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_data
);

  logic signed [COORD_BITS-1:0] edge_coord [pec_pkg::NUM_EDGE_REGS];
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                         have_prev_r;
  logic signed [COORD_BITS-1:0] s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  logic                         s1_check_r, s1_first_r, s1_valid_r;
  logic                         s2_check_r, s2_first_r, s2_valid_r;
  logic                         seg_r, sticky_r, out_valid_r;
  logic                         rdy1, rdy2, rdy3, in_acc;
  logic                         hit_a, hit_b, seg, sticky_nxt;

  assign cfg_ready = 1'b1;

  pec_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .edge_coord (edge_coord)
  );

  assign pt_x = $signed(in_tdata[COORD_BITS-1:0]);
  assign pt_y = $signed(in_tdata[2*COORD_BITS-1:COORD_BITS]);

  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !s2_valid_r || rdy3;
  assign rdy1      = !s1_valid_r || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sticky_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_x_r    <= pt_x;
        prev_y_r    <= pt_y;
        have_prev_r <= 1'b1;
      end
      if (rdy1) begin
        s1_valid_r <= in_tvalid;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        out_valid_r <= s2_valid_r;
        if (s2_valid_r) begin
          sticky_r <= sticky_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x1_r    <= prev_x_r;
      s1_y1_r    <= prev_y_r;
      s1_x2_r    <= pt_x;
      s1_y2_r    <= pt_y;
      s1_check_r <= have_prev_r && !in_tuser;
      s1_first_r <= in_tuser;
    end
    if (rdy2 && s1_valid_r) begin
      s2_check_r <= s1_check_r;
      s2_first_r <= s1_first_r;
    end
    if (rdy3 && s2_valid_r) begin
      seg_r <= seg;
    end
  end

  pec_edge_test #(.COORD_BITS(COORD_BITS)) u_edge_a (
    .clk  (clk),
    .load (rdy2 && s1_valid_r),
    .x1   (s1_x1_r),
    .y1   (s1_y1_r),
    .x2   (s1_x2_r),
    .y2   (s1_y2_r),
    .x3   (edge_coord[pec_pkg::CFG_EDGE_A_SX]),
    .y3   (edge_coord[pec_pkg::CFG_EDGE_A_SY]),
    .x4   (edge_coord[pec_pkg::CFG_EDGE_A_EX]),
    .y4   (edge_coord[pec_pkg::CFG_EDGE_A_EY]),
    .hit  (hit_a)
  );

  pec_edge_test #(.COORD_BITS(COORD_BITS)) u_edge_b (
    .clk  (clk),
    .load (rdy2 && s1_valid_r),
    .x1   (s1_x1_r),
    .y1   (s1_y1_r),
    .x2   (s1_x2_r),
    .y2   (s1_y2_r),
    .x3   (edge_coord[pec_pkg::CFG_EDGE_B_SX]),
    .y3   (edge_coord[pec_pkg::CFG_EDGE_B_SY]),
    .x4   (edge_coord[pec_pkg::CFG_EDGE_B_EX]),
    .y4   (edge_coord[pec_pkg::CFG_EDGE_B_EY]),
    .hit  (hit_b)
  );

  assign seg        = s2_check_r && (hit_a || hit_b);
  assign sticky_nxt = (sticky_r && !s2_first_r) || seg;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, sticky_r, seg_r};

endmodule

@@ test/path_edge_crossing_checker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_edge_crossing_checker_test: self-checking bench of the crossing checker
// Streams trajectory points through the block and compares every result word
// with a table value or a predictor of the exact orientation test, the touch
// rule and the sticky flag. A directed table covers the reset state, the
// extremes and special cases. Random phases follow, each with new edge settings.
// ----------------------------------------------------------------------------
module path_edge_crossing_checker_test;

  localparam int W = 24;
  localparam int IW = pec_pkg::CFG_INDEX_W;
  localparam int COORD_MIN = -8388608;
  localparam int COORD_MAX = 8388607;
  localparam int NEAR_RANGE = 10;
  localparam int NEAR_SQ_LIMIT = 105;
  localparam logic [IW-1:0] REG_UNUSED = 8'd8;
  localparam logic [IW-1:0] REG_TOP = 8'hff;
  localparam int PLAN_LEN = 39;
  localparam int PHASES = 6;
  localparam int PHASE_POINTS = 200;
  localparam int CYCLE_LIMIT = 100000;

  typedef enum bit {ROW_POINT, ROW_REG} row_kind_t;

  typedef struct packed {
    bit seg;
    bit any;
  } crossing_t;

  typedef struct {
    row_kind_t kind;
    logic [IW-1:0] reg_idx;
    int reg_val;
    int px;
    int py;
    bit first;
    bit known;
    bit seg;
    bit any;
  } step_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  logic signed [W-1:0] edge_reg [pec_pkg::NUM_EDGE_REGS];
  logic signed [W-1:0] last_x;
  logic signed [W-1:0] last_y;
  bit have_last;
  bit sticky;

  crossing_t pending_words[$];
  step_t plan [PLAN_LEN];
  bit steady = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;
  int point_count = 0;
  int word_count = 0;
  int crossing_count = 0;
  int setting_count = 0;

  path_edge_crossing_checker #(.COORD_BITS(W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 13);
  end

  function automatic bit orient(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy);
    return (cy - ay) * (bx - ax) > (by - ay) * (cx - ax);
  endfunction

  function automatic bit close_pair(longint ax, longint ay, longint bx, longint by);
    longint dx;
    longint dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    if (dx > NEAR_RANGE || dy > NEAR_RANGE)
      return 1'b0;
    return dx * dx + dy * dy < NEAR_SQ_LIMIT;
  endfunction

  function automatic bit hits_edge(longint x1, longint y1, longint x2, longint y2,
                                   int base);
    longint x3;
    longint y3;
    longint x4;
    longint y4;
    bit straddle;
    x3 = edge_reg[base];
    y3 = edge_reg[base+1];
    x4 = edge_reg[base+2];
    y4 = edge_reg[base+3];
    straddle = (orient(x1, y1, x3, y3, x4, y4) != orient(x2, y2, x3, y3, x4, y4)) &&
               (orient(x1, y1, x2, y2, x3, y3) != orient(x1, y1, x2, y2, x4, y4));
    if (!straddle)
      return 1'b0;
    return !(close_pair(x1, y1, x3, y3) || close_pair(x1, y1, x4, y4) ||
             close_pair(x2, y2, x3, y3) || close_pair(x2, y2, x4, y4));
  endfunction

  function automatic crossing_t advance_trajectory(logic signed [W-1:0] px,
                                                   logic signed [W-1:0] py, bit first);
    crossing_t r;
    r.seg = 1'b0;
    if (first) begin
      have_last = 1'b0;
      sticky = 1'b0;
    end
    if (have_last)
      r.seg = hits_edge(last_x, last_y, px, py, 0) || hits_edge(last_x, last_y, px, py, 4);
    sticky = sticky | r.seg;
    last_x = px;
    last_y = py;
    have_last = 1'b1;
    r.any = sticky;
    return r;
  endfunction

  always @(negedge clk) begin
    crossing_t want;
    if (rst_n && out_tvalid && out_tready) begin
      word_count++;
      if (pending_words.size() == 0) begin
        $display("%0t: result word %b arrived with no point pending", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (want.seg)
          crossing_count++;
        if (out_tdata[0] !== want.seg) begin
          $display("%0t: segment_crosses expected %0b actual %0b", $time, want.seg,
                   out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== want.any) begin
          $display("%0t: any_crossing expected %0b actual %0b", $time, want.any,
                   out_tdata[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic send_point(logic [W-1:0] px, logic [W-1:0] py, bit first, bit known,
                            crossing_t typed);
    bit accepted;
    crossing_t predicted;
    accepted = 1'b0;
    while (!steady && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    in_tuser <= first;
    while (!accepted) begin
      @(negedge clk);
      if (in_tready) begin
        accepted = 1'b1;
        predicted = advance_trajectory(px, py, first);
        pending_words.insert(pending_words.size(), known ? typed : predicted);
        point_count++;
      end
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [W-1:0] val);
    bit accepted;
    accepted = 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (!accepted) begin
      @(negedge clk);
      if (cfg_ready) begin
        accepted = 1'b1;
        if (idx < pec_pkg::NUM_EDGE_REGS)
          edge_reg[idx[pec_pkg::EDGE_SEL_W-1:0]] = val;
      end
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [W-1:0] random_coord();
    case ($urandom_range(9))
      0: return W'(COORD_MIN);
      1: return W'(COORD_MAX);
      2, 3: return W'($urandom);
      default: return W'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic [W-1:0] extreme_coord();
    case ($urandom_range(3))
      0: return W'(COORD_MIN);
      1: return W'(COORD_MAX);
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_random_point;
    logic [W-1:0] px;
    logic [W-1:0] py;
    int mode;
    int base;
    longint mx;
    longint my;
    mode = int'($urandom_range(99));
    base = int'($urandom_range(1)) * 4;
    if (mode < 50) begin
      px = W'(int'($urandom_range(8192)) - 4096);
      py = W'(int'($urandom_range(8192)) - 4096);
    end else if (mode < 70) begin
      base = base + int'($urandom_range(1)) * 2;
      px = W'(edge_reg[base] + int'($urandom_range(24)) - 12);
      py = W'(edge_reg[base+1] + int'($urandom_range(24)) - 12);
    end else if (mode < 80) begin
      mx = (longint'(edge_reg[base]) + longint'(edge_reg[base+2])) / 2;
      my = (longint'(edge_reg[base+1]) + longint'(edge_reg[base+3])) / 2;
      px = W'(mx + int'($urandom_range(128)) - 64);
      py = W'(my + int'($urandom_range(128)) - 64);
    end else if (mode < 90) begin
      px = W'($urandom);
      py = W'($urandom);
    end else begin
      px = extreme_coord();
      py = extreme_coord();
    end
    send_point(px, py, $urandom_range(15) == 0, 1'b0, '0);
  endtask

  task automatic load_random_edges;
    for (int r = 0; r < pec_pkg::NUM_EDGE_REGS; r++)
      write_reg(IW'(r), random_coord());
    if ($urandom_range(1))
      write_reg(REG_UNUSED + IW'($urandom_range(247)), W'($urandom));
    setting_count++;
  endtask

  initial begin
    bool_init : begin
      for (int r = 0; r < pec_pkg::NUM_EDGE_REGS; r++)
        edge_reg[r] = '0;
      last_x = '0;
      last_y = '0;
      have_last = 1'b0;
      sticky = 1'b0;
    end
    plan = '{
      '{ROW_POINT, '0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 5, 5, 1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_SX, -2048, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_SY, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_EX, 2048, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_EY, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_SX, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_SY, -2048, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_EX, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_EY, 2048, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, REG_UNUSED, 777, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 100, -100, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 100, 100, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 110, 110, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, -100, 100, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 100, -100, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, -100, 0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 2045, -50, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 2045, 5, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MAX, COORD_MAX, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MIN, COORD_MIN, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MAX, COORD_MIN, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MIN, COORD_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_SX, COORD_MIN, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_SY, COORD_MIN, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_EX, COORD_MAX, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_A_EY, COORD_MAX, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_SX, COORD_MIN, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_SY, COORD_MAX, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_EX, COORD_MAX, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, pec_pkg::CFG_EDGE_B_EY, COORD_MIN, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REG, REG_TOP, -1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MIN, 0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MAX, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, 0, COORD_MIN, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_POINT, '0, 0, COORD_MIN, COORD_MAX, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_REG) begin
        if (i > 0 && plan[i-1].kind == ROW_POINT)
          drain();
        write_reg(plan[i].reg_idx, W'(plan[i].reg_val));
      end else begin
        send_point(W'(plan[i].px), W'(plan[i].py), plan[i].first, plan[i].known,
                   '{seg: plan[i].seg, any: plan[i].any});
      end
    end
    setting_count = 3;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      steady = (p == 2);
      load_random_edges();
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if (p == 3 && n == PHASE_POINTS / 2)
          drain();
        send_random_point();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d points and checked %0d result words, %0d of them crossings,",
             point_count, word_count, crossing_count);
    $display("over %0d edge settings including the reset and extreme edges.",
             setting_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pec_pkg.sv
rtl/pec_cfg_regs.sv
rtl/pec_edge_test.sv
rtl/path_edge_crossing_checker.sv
test/path_edge_crossing_checker_test.sv
